// ----- rtl/core/clce_pkg.sv -----
package clce_pkg;

  localparam int CAPACITY  = 256;
  localparam int WORD_BITS = 32;
  localparam int NODE_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_FWD    = 3'd2;
  localparam logic [2:0] OP_BACK   = 3'd3;
  localparam logic [2:0] OP_VIEW   = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] element;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_word;
    logic        data_valid;
    logic [8:0]  entry_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic link;
    logic post;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_link;
  } stat_t;

endpackage

// ----- rtl/core/clce_ctrl.sv -----
module clce_ctrl
  import clce_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_LINK, S_POST} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   post_ok;

  assign post_ok   = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_POST) && post_ok);
  assign out_valid = out_valid_r;

  assign cmd.load = in_valid && in_ready;
  assign cmd.exec = (state_r == S_EXEC);
  assign cmd.link = (state_r == S_LINK);
  assign cmd.post = (state_r == S_POST) && post_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= stat.need_link ? S_LINK : S_POST;
        end
        S_LINK: begin
          state_r <= S_POST;
        end
        S_POST: begin
          if (post_ok) state_r <= in_valid ? S_EXEC : S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (cmd.post) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_link_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LINK) |-> ($past(state_r) == S_EXEC))
    else $error("link pass without a preceding execute cycle");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EXEC) || (state_r == S_LINK)) |-> !in_ready)
    else $error("input taken while an operation is in flight");

  a_out_from_post: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_POST))
    else $error("result presented without a post cycle");

endmodule

// ----- rtl/core/clce_datapath.sv -----
module clce_datapath
  import clce_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  in_item_t  in_data,
  output stat_t     stat,
  output out_item_t out_data
);

  logic [NODE_W-1:0]    fwd_mem [CAPACITY];
  logic [NODE_W-1:0]    bwd_mem [CAPACITY];
  logic [WORD_BITS-1:0] pay_mem [CAPACITY];
  logic [NODE_W-1:0]    stk_mem [CAPACITY];

  logic [2:0]           op_r;
  logic [31:0]          elem_r;
  logic [NODE_W-1:0]    cursor_r, cursor_nxt;
  logic [CNT_W-1:0]     occ_r, occ_nxt;
  logic [CNT_W-1:0]     free_top_r, free_top_nxt;
  // Stack entries below this mark were never pushed; the node each stands for is its own index.
  logic [CNT_W-1:0]     fresh_top_r, fresh_top_nxt;
  logic [NODE_W-1:0]    fc_r, bc_r, sv_r;
  logic [WORD_BITS-1:0] pc_r;
  logic [NODE_W-1:0]    nn_r, link_a_r;
  out_item_t            res_r, res_nxt;
  out_item_t            out_r;

  logic                 fwd_we, bwd_we, pay_we, stk_we;
  logic [NODE_W-1:0]    fwd_wa, fwd_wd, bwd_wa, bwd_wd, pay_wa, stk_wa, stk_wd;
  logic [WORD_BITS-1:0] pay_wd;

  logic [CNT_W-1:0]     top_m1;
  logic [NODE_W-1:0]    nn;
  logic                 list_empty, store_full, need_link;

  assign top_m1     = free_top_r - CNT_W'(1);
  assign nn         = (free_top_r == fresh_top_r) ? top_m1[NODE_W-1:0] : sv_r;
  assign list_empty = (occ_r == '0);
  assign store_full = (free_top_r == '0);

  always_comb begin
    cursor_nxt    = cursor_r;
    occ_nxt       = occ_r;
    free_top_nxt  = free_top_r;
    fresh_top_nxt = fresh_top_r;
    need_link     = 1'b0;
    fwd_we        = 1'b0;
    fwd_wa        = nn;
    fwd_wd        = nn;
    bwd_we        = 1'b0;
    bwd_wa        = nn;
    bwd_wd        = nn;
    pay_we        = 1'b0;
    pay_wa        = nn;
    pay_wd        = elem_r;
    stk_we        = 1'b0;
    stk_wa        = free_top_r[NODE_W-1:0];
    stk_wd        = cursor_r;
    res_nxt.status     = ST_DONE;
    res_nxt.data_word  = '0;
    res_nxt.data_valid = 1'b0;
    if (cmd.exec) begin
      unique case (op_r)
        OP_INSERT: begin
          if (store_full) begin
            res_nxt.status = ST_FULL;
          end else begin
            pay_we       = 1'b1;
            fwd_we       = 1'b1;
            bwd_we       = 1'b1;
            fwd_wd       = list_empty ? nn : fc_r;
            bwd_wd       = list_empty ? nn : cursor_r;
            free_top_nxt = top_m1;
            if (free_top_r == fresh_top_r) fresh_top_nxt = top_m1;
            cursor_nxt   = nn;
            occ_nxt      = occ_r + CNT_W'(1);
            need_link    = !list_empty;
          end
        end
        OP_REMOVE, OP_FWD, OP_BACK, OP_VIEW: begin
          if (list_empty) begin
            res_nxt.status = ST_EMPTY;
          end else if (op_r == OP_REMOVE) begin
            res_nxt.data_word  = pc_r;
            res_nxt.data_valid = 1'b1;
            fwd_we  = 1'b1;
            fwd_wa  = bc_r;
            fwd_wd  = fc_r;
            bwd_we  = 1'b1;
            bwd_wa  = fc_r;
            bwd_wd  = bc_r;
            if (free_top_r < CNT_W'(CAPACITY)) begin
              stk_we       = 1'b1;
              free_top_nxt = free_top_r + CNT_W'(1);
            end
            occ_nxt    = occ_r - CNT_W'(1);
            cursor_nxt = (occ_r == CNT_W'(1)) ? '0 : bc_r;
          end else if (op_r == OP_FWD) begin
            cursor_nxt = fc_r;
          end else if (op_r == OP_BACK) begin
            cursor_nxt = bc_r;
          end else begin
            res_nxt.data_word  = pc_r;
            res_nxt.data_valid = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.link) begin
      // Second pass of an insert: hook the new node into its neighbors.
      fwd_we = 1'b1;
      fwd_wa = link_a_r;
      fwd_wd = nn_r;
      bwd_we = 1'b1;
      bwd_wa = fc_r;
      bwd_wd = nn_r;
    end
    res_nxt.entry_count = occ_nxt;
  end

  assign stat.need_link = need_link;
  assign out_data       = out_r;

  always_ff @(posedge clk) begin
    if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
    if (bwd_we) bwd_mem[bwd_wa] <= bwd_wd;
    if (pay_we) pay_mem[pay_wa] <= pay_wd;
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (cmd.load) begin
      fc_r <= fwd_mem[cursor_r];
      bc_r <= bwd_mem[cursor_r];
      pc_r <= pay_mem[cursor_r];
      sv_r <= stk_mem[top_m1[NODE_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_data.operation;
      elem_r <= in_data.element;
    end
    if (cmd.exec) begin
      res_r    <= res_nxt;
      nn_r     <= nn;
      link_a_r <= cursor_r;
    end
    if (cmd.post) out_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      occ_r       <= '0;
      free_top_r  <= CNT_W'(CAPACITY);
      fresh_top_r <= CNT_W'(CAPACITY);
    end else begin
      cursor_r    <= cursor_nxt;
      occ_r       <= occ_nxt;
      free_top_r  <= free_top_nxt;
      fresh_top_r <= fresh_top_nxt;
    end
  end

  a_node_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(occ_r) + 32'(free_top_r)) == 32'(CAPACITY))
    else $error("listed and free node counts do not add up to the store size");

  a_fresh_mark: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_top_r <= free_top_r)
    else $error("fresh-node mark above the free stack top");

endmodule

// ----- rtl/core/circular_list_cursor_engine_core.sv -----
// Circular doubly linked list engine: one operation per input transfer (insert after the
// cursor, remove at the cursor, step forward, step back, view) and exactly one result
// transfer per operation, in order. The forward, backward, payload and free-stack stores
// are single-write-port memories with registered reads; the cursor node's links are read
// as the operation is taken and written back in the next cycle, and an insert into a
// non-empty list adds a link pass because its second pair of link writes needs another
// pass through the write ports. A finished result sits in an output register, and the
// next operation is taken in the same cycle that result is posted. Reset needs no
// clearing pass over the free stack, since nodes never handed out are tracked by a
// fill mark.
module circular_list_cursor_engine_core
  import clce_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  clce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  clce_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ----- sim/circular_list_cursor_engine_core_tb.sv -----
module circular_list_cursor_engine_core_tb
  import clce_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Operation codes the block does not define; it must answer them and change nothing.
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  circular_list_cursor_engine_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Shadow copy of the list: links, words, free-node stack, cursor and length.
  logic [NODE_W-1:0]    node_next [CAPACITY];
  logic [NODE_W-1:0]    node_prev [CAPACITY];
  logic [WORD_BITS-1:0] node_word [CAPACITY];
  logic [NODE_W-1:0]    spare_nodes [CAPACITY];
  int                   spare_top;
  logic [NODE_W-1:0]    cursor_node;
  int                   list_len;
  int                   peak_len;

  out_item_t pending_results[$];
  int        mismatches;
  int        ops_sent;
  int        results_seen;
  int        full_answers;
  int        empty_answers;
  int        in_calm;
  int        out_calm;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic out_item_t apply_list_op(in_item_t item);
    out_item_t         res;
    logic [NODE_W-1:0] fresh;
    logic [NODE_W-1:0] here;
    logic [NODE_W-1:0] prv;
    logic [NODE_W-1:0] nxt;
    res = '0;
    res.status = ST_DONE;
    here = cursor_node;
    if (item.operation == OP_INSERT) begin
      if (spare_top == 0) begin
        res.status = ST_FULL;
      end else begin
        spare_top--;
        fresh = spare_nodes[spare_top];
        node_word[fresh] = item.element;
        if (list_len == 0) begin
          node_next[fresh] = fresh;
          node_prev[fresh] = fresh;
        end else begin
          nxt = node_next[here];
          node_next[fresh] = nxt;
          node_prev[fresh] = here;
          node_prev[nxt] = fresh;
          node_next[here] = fresh;
        end
        cursor_node = fresh;
        list_len++;
        if (list_len > peak_len) peak_len = list_len;
      end
    end else if (item.operation <= OP_VIEW) begin
      if (list_len == 0) begin
        res.status = ST_EMPTY;
      end else if (item.operation == OP_REMOVE) begin
        prv = node_prev[here];
        nxt = node_next[here];
        res.data_word = node_word[here];
        res.data_valid = 1'b1;
        node_next[prv] = nxt;
        node_prev[nxt] = prv;
        if (spare_top < CAPACITY) begin
          spare_nodes[spare_top] = here;
          spare_top++;
        end
        list_len--;
        cursor_node = (list_len == 0) ? '0 : prv;
      end else if (item.operation == OP_FWD) begin
        cursor_node = node_next[here];
      end else if (item.operation == OP_BACK) begin
        cursor_node = node_prev[here];
      end else begin
        res.data_word = node_word[here];
        res.data_valid = 1'b1;
      end
    end
    res.entry_count = CNT_W'(list_len);
    return res;
  endfunction

  function automatic logic [WORD_BITS-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return WORD_BITS'($urandom);
    endcase
  endfunction

  // Sends one operation and records the result it should produce once the transfer happens.
  task automatic issue_op(logic [2:0] op, logic [WORD_BITS-1:0] word);
    int       gap;
    in_item_t item;
    if (in_calm > 0) begin
      in_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 15) == 0) in_calm = $urandom_range(10, 40);
      gap = $urandom_range(0, 5);
    end
    item.operation = op;
    item.element = word;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_list_op(item));
    ops_sent++;
  endtask

  task automatic run_op_burst(int n, int insert_pct, int remove_pct);
    int         roll;
    logic [2:0] op;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) begin
        op = OP_INSERT;
      end else if (roll < insert_pct + remove_pct) begin
        op = OP_REMOVE;
      end else if (roll >= 97) begin
        op = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
      end else begin
        case ($urandom_range(0, 2))
          0: op = OP_FWD;
          1: op = OP_BACK;
          default: op = OP_VIEW;
        endcase
      end
      issue_op(op, pick_word());
    end
  endtask

  // Every operation but insert, the undefined codes among them, against an empty list.
  task automatic test_empty_list();
    issue_op(OP_REMOVE, '1);
    issue_op(OP_FWD, '0);
    issue_op(OP_BACK, pick_word());
    issue_op(OP_VIEW, pick_word());
    for (int c = OP_RSVD_LO; c <= OP_RSVD_HI; c++) issue_op(3'(c), pick_word());
  endtask

  // Builds a short list with extreme words, walks it both ways and takes it apart again.
  task automatic test_cursor_moves();
    issue_op(OP_INSERT, '0);
    issue_op(OP_VIEW, '1);
    issue_op(OP_INSERT, '1);
    issue_op(OP_INSERT, 32'h8000_0001);
    issue_op(OP_FWD, '0);
    issue_op(OP_VIEW, '0);
    issue_op(OP_BACK, '1);
    issue_op(OP_BACK, '1);
    issue_op(OP_VIEW, '0);
    for (int c = OP_RSVD_LO; c <= OP_RSVD_HI; c++) issue_op(3'(c), '1);
    issue_op(OP_REMOVE, '0);
    issue_op(OP_VIEW, '0);
    issue_op(OP_REMOVE, '0);
    issue_op(OP_REMOVE, '0);
    issue_op(OP_REMOVE, '0);
    issue_op(OP_INSERT, 32'h7FFF_FFFE);
    issue_op(OP_REMOVE, '0);
  endtask

  task automatic test_mixed_traffic(int n);
    run_op_burst(n, 35, 30);
  endtask

  // Insert-heavy traffic pushes the store to capacity and keeps knocking on it.
  task automatic test_fill_to_capacity(int n);
    run_op_burst(n, 80, 5);
  endtask

  task automatic test_drain_to_empty(int n);
    run_op_burst(n, 5, 75);
  endtask

  // Result side: random back-pressure with calm stretches.
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      if (out_calm > 0) begin
        out_calm--;
        stall = 0;
      end else begin
        if ($urandom_range(0, 15) == 0) out_calm = $urandom_range(10, 40);
        stall = $urandom_range(0, 5);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result %p arrived with nothing expected", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        if (want.status == ST_FULL) full_answers++;
        if (want.status == ST_EMPTY) empty_answers++;
        if (out_data.status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_data.status);
        end
        if (out_data.data_word !== want.data_word) begin
          mismatches++;
          $display("%0t: data_word expected %h, got %h", $time, want.data_word,
                   out_data.data_word);
        end
        if (out_data.data_valid !== want.data_valid) begin
          mismatches++;
          $display("%0t: data_valid expected %b, got %b", $time, want.data_valid,
                   out_data.data_valid);
        end
        if (out_data.entry_count !== want.entry_count) begin
          mismatches++;
          $display("%0t: entry_count expected %0d, got %0d", $time, want.entry_count,
                   out_data.entry_count);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < CAPACITY; i++) spare_nodes[i] = NODE_W'(i);
    spare_top = CAPACITY;
    cursor_node = '0;
    list_len = 0;
    peak_len = 0;
    mismatches = 0;
    ops_sent = 0;
    results_seen = 0;
    full_answers = 0;
    empty_answers = 0;
    in_calm = 0;
    out_calm = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_cursor_moves();
    test_mixed_traffic(300);
    test_fill_to_capacity(400);
    test_drain_to_empty(450);
    test_mixed_traffic(175);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d list operations and checked %0d results, peak length %0d.",
             ops_sent, results_seen, peak_len);
    $display("%0d inserts were refused on a full store and %0d operations met an empty list.",
             full_answers, empty_answers);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
